FILE: hdl/ntis_pkg.sv
// ============================================================================
// ntis_pkg
// Shared types and constants of the nearest time index search unit.
// ============================================================================
`timescale 1ns / 1ps

package ntis_pkg;

    // Field widths of the stream words.
    localparam int ROW_ADDR_W   = 10;
    localparam int ROW_IDX_W    = 10;
    localparam int ROW_COUNT_W  = 11;
    localparam int TIME_FIELD_W = 64;
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ROW_COUNT = 1'b0;

    // Operation codes carried in tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_N1,
        S_N2,
        S_N3,
        S_DEC,
        S_DONE
    } t_state;

endpackage

FILE: hdl/ntis_ram.sv
// ============================================================================
// ntis_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`timescale 1ns / 1ps

module ntis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ntis_engine.sv
// ============================================================================
// ntis_engine
// Search sequencer: takes table writes and queries, walks the time table by
// binary search through the RAM read port, then weighs the neighbor rows.
// ============================================================================
`timescale 1ns / 1ps

module ntis_engine #(
    parameter int DEPTH      = 1024,
    parameter int TIME_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ntis_pkg::ROW_COUNT_W-1:0]    i_row_count,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ntis_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ntis_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_ram_we,
    output logic [$clog2(DEPTH)-1:0]            o_ram_waddr,
    output logic [TIME_WIDTH-1:0]               o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]            o_ram_raddr,
    input  logic [TIME_WIDTH-1:0]               i_ram_rdata
);

    import ntis_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 2;

    typedef logic signed [IW-1:0] t_idx;

    function automatic logic [TIME_WIDTH-1:0] f_dist(input logic [TIME_WIDTH-1:0] a,
                                                     input logic [TIME_WIDTH-1:0] b);
        logic signed [TIME_WIDTH:0] d;
        begin
            d = $signed({a[TIME_WIDTH-1], a}) - $signed({b[TIME_WIDTH-1], b});
            f_dist = d[TIME_WIDTH] ? TIME_WIDTH'(-d) : d[TIME_WIDTH-1:0];
        end
    endfunction

    t_state                r_state, n_state;
    logic [TIME_WIDTH-1:0] r_q, n_q;
    t_idx                  r_n, n_n;
    t_idx                  r_lo, n_lo;
    t_idx                  r_hi, n_hi;
    t_idx                  r_mid, n_mid;
    logic [TIME_WIDTH-1:0] r_d1, n_d1;
    logic [TIME_WIDTH-1:0] r_d2, n_d2;
    logic [TIME_WIDTH-1:0] r_d3, n_d3;
    logic                  r_hn, n_hn;
    logic [AW-1:0]         r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    logic [ROW_IDX_W-1:0]  r_out_row, n_out_row;

    logic                  accept;
    logic [31:0]           rc_wide;
    logic [31:0]           n_sel;
    t_idx                  n_clamped;
    logic                  plan_go;
    t_idx                  plo;
    t_idx                  phi;
    t_idx                  hm1;
    t_idx                  hp1;
    t_idx                  mid_sum;
    logic [AW-1:0]         raddr;
    logic                  ram_we;
    logic [TIME_WIDTH-1:0] dist_now;
    logic                  q_eq;
    logic                  q_lt;
    logic                  hn_now;

    assign accept    = i_s_tvalid && o_s_tready;
    assign rc_wide   = 32'(i_row_count);
    assign n_sel     = (rc_wide > 32'(DEPTH)) ? 32'(DEPTH) : rc_wide;
    assign n_clamped = t_idx'(n_sel);
    assign dist_now  = f_dist(r_q, i_ram_rdata);
    assign q_eq      = (r_q == i_ram_rdata);
    assign q_lt      = ($signed(r_q) < $signed(i_ram_rdata));
    assign hp1       = r_hi + t_idx'(1);
    assign hn_now    = (hp1 < r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_n       <= n_n;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_d1      <= n_d1;
        r_d2      <= n_d2;
        r_d3      <= n_d3;
        r_hn      <= n_hn;
        r_res     <= n_res;
        r_out_row <= n_out_row;
    end

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_d3        = r_d3;
        n_hn        = r_hn;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        raddr       = r_mid[AW-1:0];
        ram_we      = 1'b0;
        plan_go     = 1'b0;
        plo         = r_lo;
        phi         = r_hi;
        hm1         = '0;
        mid_sum     = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser == OP_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        n_q     = i_s_tdata[ROW_ADDR_W +: TIME_WIDTH];
                        n_n     = n_clamped;
                        n_lo    = '0;
                        n_hi    = n_clamped - t_idx'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                plan_go = 1'b1;
            end
            S_PROBE: begin
                if (q_eq) begin
                    n_res   = r_mid[AW-1:0];
                    n_state = S_DONE;
                end else begin
                    if (q_lt) begin
                        phi = r_mid - t_idx'(1);
                    end else begin
                        plo = r_mid + t_idx'(1);
                    end
                    plan_go = 1'b1;
                end
            end
            S_N1: begin
                n_d1    = dist_now;
                raddr   = r_hi[AW-1:0];
                n_state = S_N2;
            end
            S_N2: begin
                n_d2 = dist_now;
                n_hn = hn_now;
                if (hn_now) begin
                    raddr   = hp1[AW-1:0];
                    n_state = S_N3;
                end else begin
                    n_d3    = dist_now;
                    n_state = S_DEC;
                end
            end
            S_N3: begin
                n_d3    = dist_now;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_d1 < r_d2) begin
                    if (r_d1 < r_d3) begin
                        hm1 = r_hi - t_idx'(1);
                    end else begin
                        hm1 = r_hn ? hp1 : r_hi;
                    end
                end else if (r_d2 < r_d3) begin
                    hm1 = r_hi;
                end else begin
                    hm1 = r_hn ? hp1 : r_hi;
                end
                n_res   = hm1[AW-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = ROW_IDX_W'(r_res);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (plan_go) begin
            n_lo = plo;
            n_hi = phi;
            if (phi <= t_idx'(0)) begin
                n_res   = '0;
                n_state = S_DONE;
            end else if (plo >= phi) begin
                hm1     = phi - t_idx'(1);
                raddr   = hm1[AW-1:0];
                n_state = S_N1;
            end else begin
                mid_sum = plo + phi;
                n_mid   = mid_sum >>> 1;
                raddr   = n_mid[AW-1:0];
                n_state = S_PROBE;
            end
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = OUT_TDATA_W'(r_out_row);
    assign o_ram_we    = ram_we;
    assign o_ram_waddr = AW'(i_s_tdata[ROW_ADDR_W-1:0]);
    assign o_ram_wdata = i_s_tdata[ROW_ADDR_W +: TIME_WIDTH];
    assign o_ram_raddr = raddr;

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ((r_lo <= r_mid) && (r_mid < r_hi)))
        else $error("Probe row lies outside the search range.");

    a_neighbor_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_N1) |-> ((r_hi > t_idx'(0)) && (r_hi < r_n)))
        else $error("Neighbor phase started on an invalid row.");

    a_result_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (($signed({2'b00, r_res}) < r_n) || (r_res == '0)))
        else $error("Result row is beyond the row count.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_s_tuser == OP_QUERY)) |=> !o_s_tready)
        else $error("A new word was offered while a query is in progress.");

endmodule

FILE: hdl/nearest_time_index_search_unit.sv
// ============================================================================
// nearest_time_index_search_unit
// Holds an ascending table of signed fixed-point time stamps, written word by
// word on the input stream, and answers each query word with the index of the
// row whose time is nearest the query time. A write word (tuser low) stores
// its time at its row address and gives no output word. A query word (tuser
// high) runs a binary search over rows 0 to row_count-1 (at most DEPTH-1),
// one table read per cycle from the single read port of the time table RAM,
// then reads the up to three rows around the closing point and picks the
// nearest, the later row on a tie. The search ends early, without neighbor
// reads, on an exact match or when it closes at row 0. One query is in
// flight at a time; a finished result waits in the output register while
// the next word is taken. Entries must be written before a query can reach
// them; the user must write row_count over the register port only while
// the unit is idle; the block itself does not enforce this.
// ============================================================================
`timescale 1ns / 1ps

module nearest_time_index_search_unit #(
    parameter int DEPTH      = 1024,
    parameter int TIME_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ntis_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ntis_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ntis_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: row_address[9:0], time_value[73:10], zero fill [79:74].
    input  logic [ntis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: op[0].
    input  logic                                s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: row_index[9:0], zero fill [15:10].
    output logic [ntis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import ntis_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [ROW_COUNT_W-1:0] r_row_count;
    logic                   reg_hit;
    logic                   reg_wr;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [TIME_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [TIME_WIDTH-1:0]  ram_rdata;

    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_ROW_COUNT);
    assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(r_row_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
        end else if (reg_wr) begin
            r_row_count <= pwdata[ROW_COUNT_W-1:0];
        end
    end

    ntis_engine #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_count (r_row_count),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    ntis_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: bench/nearest_time_index_search_unit_tb.sv
// ============================================================================
// nearest_time_index_search_unit_tb
// Self-checking bench for the nearest time index search unit. It writes time
// tables over the input stream and sets row_count over the register port
// between phases. Each query is predicted by a software binary search and
// compared with the returned row index. The stimulus has a short directed
// part and then random phases of ascending tables with exact, near, midpoint
// and out-of-range queries, a few unsorted entries, and one full table with
// row_count at 1024 and above. The stream valid and ready are throttled in
// three idling modes.
// ============================================================================
`timescale 1ns / 1ps

module nearest_time_index_search_unit_tb;

    import ntis_pkg::*;

    localparam int TABLE_ROWS    = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 15;
    localparam int FULL_PHASE    = 7;
    localparam logic [63:0] KEY_FLIP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [APB_ADDR_W-1:0] ROW_COUNT_ADDR = APB_ADDR_W'(4 * REG_ROW_COUNT);

    class nearest_row_scoreboard;
        logic [TIME_FIELD_W-1:0] stamp[TABLE_ROWS];
        logic [ROW_COUNT_W-1:0]  row_count;
        logic [ROW_IDX_W-1:0]    expected_rows[$];
        int                      errors;

        function new();
            row_count = '0;
            errors = 0;
        endfunction

        function logic [63:0] order_key(logic [63:0] t);
            return t ^ KEY_FLIP;
        endfunction

        function logic [63:0] gap_between(logic [63:0] a, logic [63:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function logic [ROW_IDX_W-1:0] nearest_row(logic [63:0] t);
            logic [63:0] q;
            logic [63:0] probe;
            logic [63:0] d_lo;
            logic [63:0] d_mid;
            logic [63:0] d_hi;
            int n;
            int lo;
            int hi;
            int mid;
            bit has_next;
            q = order_key(t);
            n = (row_count > TABLE_ROWS) ? TABLE_ROWS : int'(row_count);
            lo = 0;
            hi = n - 1;
            while (hi > 0 && lo < hi) begin
                mid = (lo + hi) / 2;
                probe = order_key(stamp[mid]);
                if (q == probe) return ROW_IDX_W'(mid);
                if (q < probe) hi = mid - 1;
                else lo = mid + 1;
            end
            if (hi <= 0) return '0;
            has_next = (hi + 1) < n;
            d_lo = gap_between(q, order_key(stamp[hi - 1]));
            d_mid = gap_between(q, order_key(stamp[hi]));
            d_hi = has_next ? gap_between(q, order_key(stamp[hi + 1])) : d_mid;
            if (d_lo < d_mid) begin
                if (d_lo < d_hi) return ROW_IDX_W'(hi - 1);
                return ROW_IDX_W'(has_next ? hi + 1 : hi);
            end
            if (d_mid < d_hi) return ROW_IDX_W'(hi);
            return ROW_IDX_W'(has_next ? hi + 1 : hi);
        endfunction

        function void note_word(logic op, logic [ROW_ADDR_W-1:0] addr, logic [63:0] t);
            if (op == OP_WRITE) stamp[addr] = t;
            else expected_rows.push_back(nearest_row(t));
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] word);
            logic [ROW_IDX_W-1:0] want;
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("result word %h with no query waiting", word));
                return;
            end
            want = expected_rows.pop_front();
            if (word[ROW_IDX_W-1:0] !== want)
                report_mismatch($sformatf("row_index %0d, expected %0d",
                                          word[ROW_IDX_W-1:0], want));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    nearest_row_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int cur_rows;

    nearest_time_index_search_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic op, input logic [ROW_ADDR_W-1:0] addr,
                             input logic [63:0] t);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = IN_TDATA_W'({t, addr});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(op, addr, t);
    endtask

    task automatic store(input int row, input logic [63:0] t);
        send_word(OP_WRITE, ROW_ADDR_W'(row), t);
    endtask

    task automatic ask(input logic [63:0] t);
        send_word(OP_QUERY, ROW_ADDR_W'($urandom_range(TABLE_ROWS - 1)), t);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_row_count(input logic [ROW_COUNT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ROW_COUNT_ADDR;
        pwdata = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.row_count = value;
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[ROW_COUNT_W-1:0] !== value)
            sb.report_mismatch($sformatf("row_count reads %0d, expected %0d",
                                         prdata[ROW_COUNT_W-1:0], value));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        @(posedge i_clk);
        cur_rows = int'(value);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                in_idle_pct = 13;
                out_idle_pct = 66;
            end
            1: begin
                in_idle_pct = 66;
                out_idle_pct = 13;
            end
            default: begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
        endcase
    endtask

    // Rows 0 to n-1 get ascending times inside a window of 2**w keys, which
    // gives wide spreads, tight clusters and runs of equal times.
    task automatic fill_rows(input int n);
        logic [63:0] base;
        logic [63:0] step;
        logic [63:0] sub;
        int w;
        case ($urandom_range(7))
            0: w = 64;
            1: w = 3;
            default: w = $urandom_range(8, 63);
        endcase
        base = (w == 64) ? 64'h0 : (rand64() >> w) << w;
        step = (w == 64) ? 64'hFFFF_FFFF_FFFF_FFFF / n : (64'd1 << w) / n;
        for (int i = 0; i < n; i++) begin
            sub = 64'(i) * step + ((step > 1) ? rand64() % step : 64'h0);
            store(i, (base + sub) ^ KEY_FLIP);
        end
    endtask

    function automatic logic [63:0] pick_query_time();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        int n;
        int r;
        n = (cur_rows > TABLE_ROWS) ? TABLE_ROWS : cur_rows;
        if (n == 0) return rand64();
        r = $urandom_range(n - 1);
        a = sb.stamp[r] ^ KEY_FLIP;
        b = (r + 1 < n) ? sb.stamp[r + 1] ^ KEY_FLIP : a;
        case ($urandom_range(7))
            0, 1: q = a;
            2: q = a + $urandom_range(1, 255);
            3: q = a - $urandom_range(1, 255);
            4: q = (b >= a) ? a + (b - a) / 2 : b + (a - b) / 2;
            5: q = a + (rand64() >> $urandom_range(4, 63));
            6: q = rand64();
            default: q = $urandom_range(1) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return q ^ KEY_FLIP;
    endfunction

    task automatic run_queries(input int count);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2 || $urandom_range(49) == 0) drain_results();
            if ($urandom_range(9) == 0) store($urandom_range(TABLE_ROWS - 1), rand64());
            ask(pick_query_time());
        end
    endtask

    initial begin
        int n;
        sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_WRITE;
        cur_rows = 0;
        set_idle(0);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        set_row_count(11'd0);
        ask(TIME_MAX);
        store(0, TIME_MIN);
        store(1, 64'hFFFF_FFFD_0000_0000);
        store(2, 64'h0);
        store(3, 64'h0);
        store(4, 64'h0000_0007_0000_0000);
        store(5, TIME_MAX);
        store(TABLE_ROWS - 1, 64'h0000_0001_8000_0000);
        set_row_count(11'd1);
        ask(64'h0);
        ask(TIME_MIN);
        set_row_count(11'd2);
        ask(TIME_MIN);
        ask(TIME_MAX);
        set_row_count(11'd6);
        ask(TIME_MIN);
        ask(64'hFFFF_FFFD_0000_0000);
        ask(64'h0);
        ask(64'h0000_0007_0000_0000);
        ask(TIME_MAX);
        ask(64'hFFFF_FFFE_8000_0000);
        ask(64'h1);
        ask(TIME_MAX - 1);
        ask(TIME_MIN + 1);
        ask(64'h0000_0006_0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            set_idle(p * 3 / PHASES);
            if (p == FULL_PHASE) begin
                set_row_count(11'd1024);
                fill_rows(TABLE_ROWS);
                run_queries(30);
                set_row_count(11'd2047);
                run_queries(15);
                set_row_count(11'd1025);
                run_queries(10);
            end
            n = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(5, 32);
            set_row_count(ROW_COUNT_W'(n));
            fill_rows(n);
            if ($urandom_range(3) == 0) store($urandom_range(n - 1), rand64());
            run_queries(20);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ntis_pkg.sv
hdl/ntis_ram.sv
hdl/ntis_engine.sv
hdl/nearest_time_index_search_unit.sv
bench/nearest_time_index_search_unit_tb.sv
